>>> hw/rtl/lmrr_pkg.sv
// Shared constants, codes and types of the lock manager with revoke/retry callbacks.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package lmrr_pkg;

  // Field widths of the request and reply beats and of the lock phase
  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned LOCK_W   = 6;
  localparam int unsigned CLIENT_W = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NOTICE_W = 2;
  localparam int unsigned PHASE_W  = 2;

  // Default sizes
  localparam int unsigned LOCK_COUNT_DEF   = 64;
  localparam int unsigned CLIENT_COUNT_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF  = 16;

  // Request kinds
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

  // Lock phases
  localparam logic [PHASE_W-1:0] PH_FREE     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LOCKED   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_REVOKING = 2'd2;
  localparam logic [PHASE_W-1:0] PH_RETRYING = 2'd3;

  // Reply status codes
  localparam logic [STATUS_W-1:0] RS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] RS_RETRY = 2'd1;
  localparam logic [STATUS_W-1:0] RS_FULL  = 2'd2;

  // Callback kinds
  localparam logic [NOTICE_W-1:0] NOTE_NONE   = 2'd0;
  localparam logic [NOTICE_W-1:0] NOTE_REVOKE = 2'd1;
  localparam logic [NOTICE_W-1:0] NOTE_RETRY  = 2'd2;

  // One reply beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NOTICE_W-1:0] kind;
    logic [CLIENT_W-1:0] client;
    logic [LOCK_W-1:0]   lock;
  } reply_t;

endpackage

`default_nettype wire

>>> hw/rtl/lmrr_req_if.sv
// Request channel: valid/ready handshake carrying one acquire or release beat.
// Depends on lmrr_pkg for the field widths.
`default_nettype none

interface lmrr_req_if;
  logic                          valid;
  logic                          ready;
  logic [lmrr_pkg::FUNC_W-1:0]   func;
  logic [lmrr_pkg::LOCK_W-1:0]   lock_index;
  logic [lmrr_pkg::CLIENT_W-1:0] requester;

  modport source (output valid, output func, output lock_index, output requester,
                  input ready);
  modport sink   (input valid, input func, input lock_index, input requester,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lmrr_rsp_if.sv
// Reply channel: valid/ready handshake carrying the reply status and callback notice.
// Depends on lmrr_pkg for the field widths.
`default_nettype none

interface lmrr_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lmrr_pkg::STATUS_W-1:0]   reply_status;
  logic [lmrr_pkg::NOTICE_W-1:0]   notice_kind;
  logic [lmrr_pkg::CLIENT_W-1:0]   notice_client;
  logic [lmrr_pkg::LOCK_W-1:0]     notice_lock;

  modport source (output valid, output reply_status, output notice_kind,
                  output notice_client, output notice_lock, input ready);
  modport sink   (input valid, input reply_status, input notice_kind,
                  input notice_client, input notice_lock, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lock_manager_revoke_retry.sv
// Lock manager with revoke/retry callbacks: one request beat in, one reply beat out.
// The lock entry (phase, holder, retry grantee, queue head and count) of a request is read
// from the entry memory at acceptance, the read state then reads the waiter at the queue head
// from the waiter memory, and the write state writes both back and loads the reply register.
// Requests are handled one at a time, so no new one is taken until the previous one has been
// written back, which needs the reply register to be free; an unread reply holds the write
// state.
// After reset a clearing pass zeroes the entry memory; no request is accepted during it.
// Depends on lmrr_pkg, lmrr_req_if, lmrr_rsp_if and lmrr_step.
`default_nettype none

module lock_manager_revoke_retry #(
  parameter int unsigned LOCK_COUNT   = lmrr_pkg::LOCK_COUNT_DEF,
  parameter int unsigned CLIENT_COUNT = lmrr_pkg::CLIENT_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH  = lmrr_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  lmrr_req_if.sink   req_i,
  lmrr_rsp_if.source rsp_o
);

  localparam int unsigned LK_W   = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int unsigned QD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CL_W   = lmrr_pkg::CLIENT_W;
  localparam int unsigned PH_W   = lmrr_pkg::PHASE_W;
  localparam int unsigned ENT_W  = PH_W + 2 * CL_W + QD_W + CNT_W;
  localparam int unsigned LK_IN  = 1 << lmrr_pkg::LOCK_W;
  localparam int unsigned CL_IN  = 1 << lmrr_pkg::CLIENT_W;

  // Controller states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [LK_W-1:0] clr_q, clr_d;

  logic [LK_W-1:0] lk_map [LK_IN];
  logic [CL_W-1:0] cl_map [CL_IN];

  logic                                accept;
  logic                                commit;
  logic [LK_W-1:0]                     lk_in;
  logic [lmrr_pkg::FUNC_W-1:0]         func_q;
  logic [LK_W-1:0]                     lk_q;
  logic [CL_W-1:0]                     cid_q;

  logic [ENT_W-1:0] entry_mem [LOCK_COUNT];
  logic [ENT_W-1:0] ent_rd_q;
  logic             ent_wr;
  logic [LK_W-1:0]  ent_wr_addr;
  logic [ENT_W-1:0] ent_wr_data;

  logic [CL_W-1:0]  wait_mem [LOCK_COUNT][QUEUE_DEPTH];
  logic [CL_W-1:0]  wait_rd_q;

  logic [PH_W-1:0]  r_phase, n_phase;
  logic [CL_W-1:0]  r_holder, n_holder;
  logic [CL_W-1:0]  r_grantee, n_grantee;
  logic [QD_W-1:0]  r_head, n_head;
  logic [CNT_W-1:0] r_count, n_count;
  logic             q_wr;
  logic [QD_W-1:0]  q_slot;
  lmrr_pkg::reply_t step_reply;

  logic             out_valid_q, out_valid_d;
  lmrr_pkg::reply_t reply_q;

  // Index reduction tables, worked out at elaboration
  for (genvar g = 0; g < LK_IN; g++) begin : g_lk_map
    assign lk_map[g] = LK_W'(g % LOCK_COUNT);
  end
  for (genvar g = 0; g < CL_IN; g++) begin : g_cl_map
    assign cl_map[g] = CL_W'(g % CLIENT_COUNT);
  end

  // Handshake
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign commit      = (state_q == ST_WRITE) && (!out_valid_q || rsp_o.ready);
  assign lk_in       = lk_map[req_i.lock_index];

  // Controller
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + LK_W'(1);
        if (clr_q == LK_W'(LOCK_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      lk_q   <= lk_in;
      cid_q  <= cl_map[req_i.requester];
    end
  end

  // Entry memory: read at acceptance, written by the clearing pass or at commit
  assign ent_wr      = (state_q == ST_CLEAR) || commit;
  assign ent_wr_addr = (state_q == ST_CLEAR) ? clr_q : lk_q;
  assign ent_wr_data = (state_q == ST_CLEAR) ? '0 :
                       {n_phase, n_holder, n_grantee, n_head, n_count};

  always_ff @(posedge clk_i) begin
    if (ent_wr) begin
      entry_mem[ent_wr_addr] <= ent_wr_data;
    end
    if (accept) begin
      ent_rd_q <= entry_mem[lk_in];
    end
  end

  assign {r_phase, r_holder, r_grantee, r_head, r_count} = ent_rd_q;

  // Waiter memory: head slot read once the entry is known, tail slot written at commit
  always_ff @(posedge clk_i) begin
    if (commit && q_wr) begin
      wait_mem[lk_q][q_slot] <= cid_q;
    end
    if (state_q == ST_READ) begin
      wait_rd_q <= wait_mem[lk_q][r_head];
    end
  end

  // Decision
  lmrr_step #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_step (
    .func_i        (func_q),
    .lock_i        (lmrr_pkg::LOCK_W'(lk_q)),
    .client_i      (cid_q),
    .phase_i       (r_phase),
    .holder_i      (r_holder),
    .grantee_i     (r_grantee),
    .head_i        (r_head),
    .count_i       (r_count),
    .head_client_i (wait_rd_q),
    .phase_o       (n_phase),
    .holder_o      (n_holder),
    .grantee_o     (n_grantee),
    .head_o        (n_head),
    .count_o       (n_count),
    .q_wr_o        (q_wr),
    .q_slot_o      (q_slot),
    .reply_o       (step_reply)
  );

  // Reply register
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      reply_q <= step_reply;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.reply_status  = reply_q.status;
  assign rsp_o.notice_kind   = reply_q.kind;
  assign rsp_o.notice_client = reply_q.client;
  assign rsp_o.notice_lock   = reply_q.lock;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> r_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_enqueue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && q_wr |-> r_count < CNT_W'(QUEUE_DEPTH))
    else $error("enqueue into a full queue");

  a_reply_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_WRITE)
    else $error("reply raised without a commit");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_READ)
    else $error("accepted request did not start a read");

  a_quiet_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && reply_q.kind == lmrr_pkg::NOTE_NONE |->
      reply_q.client == '0 && reply_q.lock == '0)
    else $error("notice fields set without a notice");

endmodule

`default_nettype wire

>>> hw/rtl/lmrr_step.sv
// Per-request decision logic: from one lock entry, the queue head client and the request,
// computes the updated entry, the waiter slot to write and the reply. Uses lmrr_pkg.
`default_nettype none

module lmrr_step #(
  parameter int unsigned QUEUE_DEPTH = lmrr_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned QD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic [lmrr_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [lmrr_pkg::LOCK_W-1:0]   lock_i,
  input  wire logic [lmrr_pkg::CLIENT_W-1:0] client_i,
  input  wire logic [lmrr_pkg::PHASE_W-1:0]  phase_i,
  input  wire logic [lmrr_pkg::CLIENT_W-1:0] holder_i,
  input  wire logic [lmrr_pkg::CLIENT_W-1:0] grantee_i,
  input  wire logic [QD_W-1:0]               head_i,
  input  wire logic [CNT_W-1:0]              count_i,
  input  wire logic [lmrr_pkg::CLIENT_W-1:0] head_client_i,
  output      logic [lmrr_pkg::PHASE_W-1:0]  phase_o,
  output      logic [lmrr_pkg::CLIENT_W-1:0] holder_o,
  output      logic [lmrr_pkg::CLIENT_W-1:0] grantee_o,
  output      logic [QD_W-1:0]               head_o,
  output      logic [CNT_W-1:0]              count_o,
  output      logic                          q_wr_o,
  output      logic [QD_W-1:0]               q_slot_o,
  output      lmrr_pkg::reply_t              reply_o
);

  localparam int unsigned SUM_W = CNT_W + 1;

  logic [SUM_W-1:0] tail_sum;
  logic [QD_W-1:0]  tail_slot;
  logic [QD_W-1:0]  head_inc;
  logic [CNT_W-1:0] count_dec;

  // Tail slot = (head + count) mod depth; the sum stays below twice the depth
  assign tail_sum  = SUM_W'(head_i) + SUM_W'(count_i);
  assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     QD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QD_W'(tail_sum);
  assign head_inc  = (head_i == QD_W'(QUEUE_DEPTH - 1)) ? '0 : head_i + QD_W'(1);
  assign count_dec = count_i - CNT_W'(1);

  // Decision tree
  always_comb begin
    phase_o   = phase_i;
    holder_o  = holder_i;
    grantee_o = grantee_i;
    head_o    = head_i;
    count_o   = count_i;
    q_wr_o    = 1'b0;
    q_slot_o  = tail_slot;
    reply_o   = '0;
    if (func_i == lmrr_pkg::FUNC_ACQUIRE) begin
      if (phase_i == lmrr_pkg::PH_FREE) begin
        phase_o        = lmrr_pkg::PH_LOCKED;
        holder_o       = client_i;
        reply_o.status = lmrr_pkg::RS_OK;
      end else if (phase_i == lmrr_pkg::PH_RETRYING && grantee_i == client_i) begin
        holder_o       = client_i;
        reply_o.status = lmrr_pkg::RS_OK;
        // pop the grantee; others still waiting means revoke it right away
        if (count_i != '0) begin
          head_o  = head_inc;
          count_o = count_dec;
        end
        if (count_i > CNT_W'(1)) begin
          phase_o        = lmrr_pkg::PH_REVOKING;
          reply_o.kind   = lmrr_pkg::NOTE_REVOKE;
          reply_o.client = client_i;
          reply_o.lock   = lock_i;
        end else begin
          phase_o = lmrr_pkg::PH_LOCKED;
        end
      end else if (count_i >= CNT_W'(QUEUE_DEPTH)) begin
        reply_o.status = lmrr_pkg::RS_FULL;
      end else begin
        q_wr_o         = 1'b1;
        count_o        = count_i + CNT_W'(1);
        reply_o.status = lmrr_pkg::RS_RETRY;
        if (phase_i == lmrr_pkg::PH_LOCKED) begin
          phase_o        = lmrr_pkg::PH_REVOKING;
          reply_o.kind   = lmrr_pkg::NOTE_REVOKE;
          reply_o.client = holder_i;
          reply_o.lock   = lock_i;
        end
      end
    end else begin
      reply_o.status = lmrr_pkg::RS_OK;
      if (count_i == '0) begin
        phase_o = lmrr_pkg::PH_FREE;
      end else begin
        phase_o        = lmrr_pkg::PH_RETRYING;
        grantee_o      = head_client_i;
        reply_o.kind   = lmrr_pkg::NOTE_RETRY;
        reply_o.client = head_client_i;
        reply_o.lock   = lock_i;
      end
    end
  end

endmodule

`default_nettype wire
